// ----- hw/rtl/sdh_pkg.sv -----
package sdh_pkg;

   localparam int MaxSteps  = 24;
   localparam int FracShift = 24;
   localparam int CxW       = 42;
   localparam int ZW        = 24;

   localparam logic [1:0] REG_AXIS_DEADBAND  = 2'd0;
   localparam logic [1:0] REG_RESCALE_GAIN   = 2'd1;
   localparam logic [1:0] REG_HEADING_X_BAND = 2'd2;
   localparam logic [1:0] REG_HEADING_Y_BAND = 2'd3;

   localparam logic [14:0] DEADBAND_RST = 15'd3277;
   localparam logic [15:0] GAIN_RST     = 16'd18204;
   localparam logic [14:0] XBAND_RST    = 15'd2458;
   localparam logic [14:0] YBAND_RST    = 15'd1638;

   localparam logic [13:0]        RIGHT_ANGLE = 14'd9000;
   localparam logic signed [15:0] HALF_TURN   = 16'sd18000;

   typedef struct packed {
      logic in_band;
      logic y_low;
      logic x_neg;
      logic y_neg;
      logic ay_zero;
      logic ax_zero;
   } hdg_flags_type;

   typedef struct packed {
      logic signed [15:0] cond_x;
      logic signed [15:0] cond_y;
      logic signed [15:0] heading;
   } rsp_word_type;

   // atan(2^-i) in 1/256 centidegree
   function automatic logic [20:0] atan_entry(input int i);
      logic [20:0] r;
      case (i)
         0:       r = 21'd1152000;
         1:       r = 21'd680065;
         2:       r = 21'd359328;
         3:       r = 21'd182400;
         4:       r = 21'd91554;
         5:       r = 21'd45822;
         6:       r = 21'd22916;
         7:       r = 21'd11459;
         8:       r = 21'd5730;
         9:       r = 21'd2865;
         10:      r = 21'd1432;
         11:      r = 21'd716;
         12:      r = 21'd358;
         13:      r = 21'd179;
         14:      r = 21'd90;
         15:      r = 21'd45;
         16:      r = 21'd22;
         17:      r = 21'd11;
         18:      r = 21'd6;
         19:      r = 21'd3;
         20:      r = 21'd1;
         21:      r = 21'd1;
         default: r = 21'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/stick_deadband_heading.sv -----
// Stick conditioning and heading.
// Input channel req_*: one stick sample per word (present flag, raw X, raw Y in Q1.15),
// accepted when req_valid and req_ready are both high. Result channel rsp_*: conditioned
// X, inverted conditioned Y and heading in centidegrees, one word per sample, in order.
// csr_*: write-only register port; the user must write it only while no sample is in
// flight, and the block itself does not enforce it. Throughput: one sample per cycle
// while the receiver does not stall, set by the fully pipelined datapath: four
// conditioning stages, a prep stage, one stage per CORDIC iteration and an angle stage.
// Reset (synchronous, active high) empties the pipeline, drops any pending word and
// restores the default register values; req_ready is high in the first cycle after it.
// When the receiver stalls, the pending word holds on rsp_* and one more word is caught
// in a skid register; req_ready then drops and the whole pipeline holds until the
// receiver takes the pending word. Nothing is lost or repeated across a stall.
module stick_deadband_heading #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_stick_present,
   input  logic signed [15:0] req_raw_x,
   input  logic signed [15:0] req_raw_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_cond_x,
   output logic signed [15:0] rsp_cond_y,
   output logic signed [15:0] rsp_heading_centideg,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import sdh_pkg::*;

   logic [14:0] deadband_ff;
   logic [15:0] gain_ff;
   logic [14:0] xband_ff;
   logic [14:0] yband_ff;

   logic adv;
   logic skid_full_ff;
   logic rsp_valid_ff;
   rsp_word_type out_ff;
   rsp_word_type skid_ff;
   rsp_word_type fin_in;

   logic               s1_valid_ff;
   logic               s1_xneg_ff, s1_yneg_ff;
   logic [15:0]        s1_xmag_ff, s1_ymag_ff;
   logic               s2_valid_ff;
   logic               s2_xneg_ff, s2_yneg_ff, s2_xdz_ff, s2_ydz_ff;
   logic [15:0]        s2_xm_ff, s2_ym_ff;
   logic               s3_valid_ff;
   logic               s3_xneg_ff, s3_yneg_ff, s3_xdz_ff, s3_ydz_ff;
   logic [31:0]        s3_xp_ff, s3_yp_ff;
   logic               s4_valid_ff;
   logic signed [15:0] s4_x_ff, s4_y_ff;

   logic signed [16:0] s0_x, s0_y;
   logic [16:0]        s0_xabs, s0_yabs;
   logic signed [16:0] p_x17, p_y17, p_xb17, p_yb17;
   logic [15:0]        p_ax, p_ay;
   hdg_flags_type      p_flags;

   logic                  cv_ff  [0:CORDIC_STEPS];
   logic signed [CxW-1:0] cx_ff  [0:CORDIC_STEPS];
   logic signed [CxW-1:0] cy_ff  [0:CORDIC_STEPS];
   logic signed [ZW-1:0]  cz_ff  [0:CORDIC_STEPS];
   logic signed [15:0]    cox_ff [0:CORDIC_STEPS];
   logic signed [15:0]    coy_ff [0:CORDIC_STEPS];
   hdg_flags_type         cfl_ff [0:CORDIC_STEPS];

   logic               f_valid_ff;
   logic [13:0]        f_ang_ff;
   logic signed [15:0] f_x_ff, f_y_ff;
   hdg_flags_type      f_flags_ff;
   logic [ZW-2:0]      f_zc;
   logic [ZW-1:0]      f_rnd;
   logic [14:0]        f_araw;
   logic [13:0]        f_ang_in;
   logic signed [15:0] f_half;

   logic out_take, out_free;

   function automatic logic signed [15:0] scale_sat(input logic neg, input logic dz,
                                                   input logic [31:0] prod);
      logic [32:0]        rnd;
      logic [18:0]        p;
      logic signed [15:0] r;
      rnd = {1'b0, prod} + 33'd8192;
      p   = rnd[32:14];
      if (dz) begin
         r = '0;
      end else if (neg) begin
         r = (p > 19'd32768) ? -16'sd32768 : $signed(~p[15:0] + 16'd1);
      end else begin
         r = (p > 19'd32767) ? 16'sd32767 : $signed(p[15:0]);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RST;
         gain_ff     <= GAIN_RST;
         xband_ff    <= XBAND_RST;
         yband_ff    <= YBAND_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_AXIS_DEADBAND:  deadband_ff <= csr_wdata[14:0];
            REG_RESCALE_GAIN:   gain_ff     <= csr_wdata;
            REG_HEADING_X_BAND: xband_ff    <= csr_wdata[14:0];
            REG_HEADING_Y_BAND: yband_ff    <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   assign adv       = !skid_full_ff;
   assign req_ready = adv;

   always_comb begin
      s0_x    = req_stick_present ? 17'(req_raw_x) : '0;
      s0_y    = req_stick_present ? -17'(req_raw_y) : '0;
      s0_xabs = s0_x[16] ? 17'(-s0_x) : 17'(s0_x);
      s0_yabs = s0_y[16] ? 17'(-s0_y) : 17'(s0_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_xneg_ff <= s0_x[16];
         s1_yneg_ff <= s0_y[16];
         s1_xmag_ff <= s0_xabs[15:0];
         s1_ymag_ff <= s0_yabs[15:0];

         s2_xneg_ff <= s1_xneg_ff;
         s2_yneg_ff <= s1_yneg_ff;
         s2_xdz_ff  <= s1_xmag_ff <= {1'b0, deadband_ff};
         s2_ydz_ff  <= s1_ymag_ff <= {1'b0, deadband_ff};
         s2_xm_ff   <= s1_xmag_ff - {1'b0, deadband_ff};
         s2_ym_ff   <= s1_ymag_ff - {1'b0, deadband_ff};

         s3_xneg_ff <= s2_xneg_ff;
         s3_yneg_ff <= s2_yneg_ff;
         s3_xdz_ff  <= s2_xdz_ff;
         s3_ydz_ff  <= s2_ydz_ff;
         s3_xp_ff   <= 32'(s2_xm_ff) * 32'(gain_ff);
         s3_yp_ff   <= 32'(s2_ym_ff) * 32'(gain_ff);

         s4_x_ff <= scale_sat(s3_xneg_ff, s3_xdz_ff, s3_xp_ff);
         s4_y_ff <= scale_sat(s3_yneg_ff, s3_ydz_ff, s3_yp_ff);
      end
   end

   always_comb begin
      p_x17  = 17'(s4_x_ff);
      p_y17  = 17'(s4_y_ff);
      p_xb17 = $signed({2'b00, xband_ff});
      p_yb17 = $signed({2'b00, yband_ff});
      p_ax   = s4_x_ff[15] ? (~s4_x_ff + 16'd1) : s4_x_ff;
      p_ay   = s4_y_ff[15] ? (~s4_y_ff + 16'd1) : s4_y_ff;
      p_flags.in_band = (p_x17 > -p_xb17) && (p_x17 < p_xb17);
      p_flags.y_low   = !(p_y17 > -p_yb17);
      p_flags.x_neg   = s4_x_ff[15];
      p_flags.y_neg   = s4_y_ff[15];
      p_flags.ay_zero = (p_ay == '0);
      p_flags.ax_zero = (p_ax == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]  <= $signed({2'b00, p_ax, FracShift'(0)});
         cy_ff[0]  <= $signed({2'b00, p_ay, FracShift'(0)});
         cz_ff[0]  <= '0;
         cox_ff[0] <= s4_x_ff;
         coy_ff[0] <= s4_y_ff;
         cfl_ff[0] <= p_flags;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CxW-1:0] cx_in, cy_in;
      logic signed [ZW-1:0]  cz_in, ang;

      always_comb begin
         ang = $signed({3'b000, atan_entry(i)});
         if (cy_ff[i] >= 0) begin
            cx_in = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in = cz_ff[i] + ang;
         end else begin
            cx_in = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in = cz_ff[i] - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[i+1]  <= cx_in;
            cy_ff[i+1]  <= cy_in;
            cz_ff[i+1]  <= cz_in;
            cox_ff[i+1] <= cox_ff[i];
            coy_ff[i+1] <= coy_ff[i];
            cfl_ff[i+1] <= cfl_ff[i];
         end
      end
   end

   always_comb begin
      f_zc   = cz_ff[CORDIC_STEPS][ZW-1] ? '0 : cz_ff[CORDIC_STEPS][ZW-2:0];
      f_rnd  = {1'b0, f_zc} + ZW'(128);
      f_araw = f_rnd[22:8];
      if (cfl_ff[CORDIC_STEPS].ay_zero) begin
         f_ang_in = '0;
      end else if (cfl_ff[CORDIC_STEPS].ax_zero) begin
         f_ang_in = RIGHT_ANGLE;
      end else if (f_araw > {1'b0, RIGHT_ANGLE}) begin
         f_ang_in = RIGHT_ANGLE;
      end else begin
         f_ang_in = f_araw[13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= cv_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ang_ff   <= f_ang_in;
         f_x_ff     <= cox_ff[CORDIC_STEPS];
         f_y_ff     <= coy_ff[CORDIC_STEPS];
         f_flags_ff <= cfl_ff[CORDIC_STEPS];
      end
   end

   always_comb begin
      f_half = f_flags_ff.y_neg ? $signed({2'b00, RIGHT_ANGLE} + {2'b00, f_ang_ff})
                                : $signed({2'b00, RIGHT_ANGLE} - {2'b00, f_ang_ff});
      fin_in.cond_x = f_x_ff;
      fin_in.cond_y = f_y_ff;
      if (f_flags_ff.in_band) begin
         fin_in.heading = f_flags_ff.y_low ? HALF_TURN : '0;
      end else begin
         fin_in.heading = f_flags_ff.x_neg ? -f_half : f_half;
      end
   end

   assign out_take = rsp_valid_ff && rsp_ready;
   assign out_free = !rsp_valid_ff || out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (out_take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (f_valid_ff) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_full_ff <= 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (f_valid_ff) begin
         if (out_free) begin
            out_ff <= fin_in;
         end else begin
            skid_ff <= fin_in;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cond_x           = out_ff.cond_x;
   assign rsp_cond_y           = out_ff.cond_y;
   assign rsp_heading_centideg = out_ff.heading;

endmodule

// ----- hw/rtl/sdh_checker.sv -----
module sdh_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_cond_x,
   input logic signed [15:0] rsp_cond_y,
   input logic signed [15:0] rsp_heading_centideg
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cond_x) && $stable(rsp_cond_y)
         && $stable(rsp_heading_centideg))
      else $error("pending word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input held off with no word pending");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading_centideg >= -16'sd18000 && rsp_heading_centideg <= 16'sd18000)
      else $error("heading out of range");

   a_half_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_heading_centideg == 16'sd18000 || rsp_heading_centideg == -16'sd18000)
         |-> rsp_cond_y <= 16'sd0)
      else $error("half turn with positive Y");

endmodule

bind stick_deadband_heading sdh_checker u_sdh_checker (.*);
